FILE: src/tpc_pkg.sv
`default_nettype none

package tpc_pkg;

   localparam int unsigned CountWidth     = 8;
   localparam int unsigned PrescaleWidth  = 10;
   localparam int unsigned ModeWidth      = 3;
   localparam int unsigned ClockSelWidth  = 3;
   localparam int unsigned ActionWidth    = 2;
   localparam int unsigned CsrIndexWidth  = 3;
   localparam int unsigned CsrDataWidth   = 8;

   localparam logic [CountWidth-1:0] CountTop    = '1;
   localparam logic [CountWidth-1:0] CountBottom = '0;

   // waveform modes
   localparam logic [ModeWidth-1:0] ModeNormal    = 3'd0;
   localparam logic [ModeWidth-1:0] ModePhasePwm  = 3'd1;
   localparam logic [ModeWidth-1:0] ModeCtc       = 3'd2;
   localparam logic [ModeWidth-1:0] ModeFastPwm   = 3'd3;

   // pin actions
   localparam logic [ActionWidth-1:0] ActNone   = 2'd0;
   localparam logic [ActionWidth-1:0] ActToggle = 2'd1;
   localparam logic [ActionWidth-1:0] ActClear  = 2'd2;
   localparam logic [ActionWidth-1:0] ActSet    = 2'd3;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] RegWaveMode   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegClockSel   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegCompareA   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegCompareB   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegActionA    = 3'd4;
   localparam logic [CsrIndexWidth-1:0] RegActionB    = 3'd5;

   typedef struct packed {
      logic [ModeWidth-1:0]     wave_mode;
      logic [ClockSelWidth-1:0] clock_select;
      logic [CountWidth-1:0]    compare_a;
      logic [CountWidth-1:0]    compare_b;
      logic [ActionWidth-1:0]   out_action_a;
      logic [ActionWidth-1:0]   out_action_b;
   } cfg_type;

   // low prescaler bits that must be zero for a counting tick
   function automatic logic [PrescaleWidth-1:0] divisor_mask(
      input logic [ClockSelWidth-1:0] sel
   );
      logic [PrescaleWidth-1:0] mask;
      unique case (sel)
         3'd2:    mask = 10'h007;
         3'd3:    mask = 10'h01F;
         3'd4:    mask = 10'h03F;
         3'd5:    mask = 10'h07F;
         3'd6:    mask = 10'h0FF;
         3'd7:    mask = 10'h3FF;
         default: mask = 10'h000;
      endcase
      return mask;
   endfunction

   // pin level after a compare match
   function automatic logic match_level(
      input logic [ModeWidth-1:0]   mode,
      input logic [ActionWidth-1:0] action,
      input logic                   level,
      input logic                   up
   );
      logic res;
      res = level;
      if (mode == ModeNormal || mode == ModeCtc) begin
         unique case (action)
            ActToggle: res = ~level;
            ActClear:  res = 1'b0;
            ActSet:    res = 1'b1;
            default:   res = level;
         endcase
      end else if (mode == ModePhasePwm) begin
         if (action == ActClear) res = ~up;
         else if (action == ActSet) res = up;
      end else if (mode == ModeFastPwm) begin
         if (action == ActClear) res = 1'b0;
         else if (action == ActSet) res = 1'b1;
      end
      return res;
   endfunction

   // pin level when the counter wraps at top (fast PWM only)
   function automatic logic top_level(
      input logic [ModeWidth-1:0]   mode,
      input logic [ActionWidth-1:0] action,
      input logic                   level
   );
      logic res;
      res = level;
      if (mode == ModeFastPwm) begin
         if (action == ActClear) res = 1'b1;
         else if (action == ActSet) res = 1'b0;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: src/tpc_csr.sv
`default_nettype none

module tpc_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 wr_en,
   input  wire logic [tpc_pkg::CsrIndexWidth-1:0]    wr_index,
   input  wire logic [tpc_pkg::CsrDataWidth-1:0]     wr_data,
   output tpc_pkg::cfg_type                          cfg
);
   import tpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            RegWaveMode: cfg_in.wave_mode    = wr_data[ModeWidth-1:0];
            RegClockSel: cfg_in.clock_select = wr_data[ClockSelWidth-1:0];
            RegCompareA: cfg_in.compare_a    = wr_data[CountWidth-1:0];
            RegCompareB: cfg_in.compare_b    = wr_data[CountWidth-1:0];
            RegActionA:  cfg_in.out_action_a = wr_data[ActionWidth-1:0];
            RegActionB:  cfg_in.out_action_b = wr_data[ActionWidth-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: src/tpc_core.sv
`default_nettype none

module tpc_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire tpc_pkg::cfg_type                    cfg,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [tpc_pkg::PrescaleWidth-1:0]   req_prescale_count,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [tpc_pkg::CountWidth-1:0]           rsp_count_value,
   output logic                                     rsp_pin_a,
   output logic                                     rsp_pin_b,
   output logic                                     rsp_overflow_flag,
   output logic                                     rsp_match_a_flag,
   output logic                                     rsp_match_b_flag
);
   import tpc_pkg::*;

   // input stage
   logic                     in_valid_ff;
   logic [PrescaleWidth-1:0] pre_ff;

   // timer state
   logic [CountWidth-1:0] counter_ff, counter_in;
   logic                  up_ff, up_in;
   logic                  level_a_ff, level_a_in;
   logic                  level_b_ff, level_b_in;

   // result stage
   logic                  out_valid_ff;
   logic [CountWidth-1:0] out_count_ff;
   logic                  out_pin_a_ff, out_pin_b_ff;
   logic                  out_ovf_ff, out_ma_ff, out_mb_ff;
   logic                  ovf_in, ma_in, mb_in;

   logic                  advance;
   logic                  load;
   logic                  tick;
   logic                  dir_up;
   logic [CountWidth-1:0] stepped;
   logic [CountWidth-1:0] top_a, top_b;
   logic [CountWidth-1:0] after_a;
   logic                  lvl_a_m, lvl_b_m;

   assign advance   = ~out_valid_ff | rsp_ready;
   assign req_ready = ~in_valid_ff | advance;
   assign load      = req_valid & req_ready;

   always_comb begin
      tick = (cfg.clock_select != '0)
          && ((pre_ff & divisor_mask(cfg.clock_select)) == '0);
      dir_up  = (cfg.wave_mode == ModePhasePwm) ? up_ff : 1'b1;
      stepped = dir_up ? counter_ff + 1'b1 : counter_ff - 1'b1;
      top_a   = (cfg.wave_mode == ModeCtc) ? cfg.compare_a : CountTop;
      top_b   = (cfg.wave_mode == ModeCtc) ? cfg.compare_b : CountTop;

      counter_in = counter_ff;
      up_in      = up_ff;
      level_a_in = level_a_ff;
      level_b_in = level_b_ff;
      ovf_in     = 1'b0;
      ma_in      = 1'b0;
      mb_in      = 1'b0;
      after_a    = stepped;
      lvl_a_m    = level_a_ff;
      lvl_b_m    = level_b_ff;

      if (tick) begin
         ovf_in = (cfg.wave_mode == ModePhasePwm) ? (stepped == CountBottom)
                                                  : (stepped == CountTop);
         ma_in  = (stepped == cfg.compare_a);
         mb_in  = (stepped == cfg.compare_b);
         if (ma_in) lvl_a_m = match_level(cfg.wave_mode, cfg.out_action_a, level_a_ff, dir_up);
         if (mb_in) lvl_b_m = match_level(cfg.wave_mode, cfg.out_action_b, level_b_ff, dir_up);
         level_a_in = lvl_a_m;
         level_b_in = lvl_b_m;
         counter_in = stepped;

         if (cfg.wave_mode == ModeNormal || cfg.wave_mode == ModeCtc
               || cfg.wave_mode == ModeFastPwm) begin
            // wrap at top A, then check the result against top B
            if (stepped == top_a) begin
               after_a    = CountBottom;
               level_a_in = top_level(cfg.wave_mode, cfg.out_action_a, lvl_a_m);
            end
            counter_in = after_a;
            if (after_a == top_b) begin
               counter_in = CountBottom;
               level_b_in = top_level(cfg.wave_mode, cfg.out_action_b, lvl_b_m);
            end
         end else if (cfg.wave_mode == ModePhasePwm) begin
            if (!up_ff) begin
               if (stepped == CountBottom) up_in = 1'b1;
            end else if (stepped == CountTop) begin
               up_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         counter_ff   <= '0;
         up_ff        <= 1'b1;
         level_a_ff   <= 1'b0;
         level_b_ff   <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance && in_valid_ff) begin
            counter_ff <= counter_in;
            up_ff      <= up_in;
            level_a_ff <= level_a_in;
            level_b_ff <= level_b_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pre_ff <= req_prescale_count;
      end
      if (advance && in_valid_ff) begin
         out_count_ff <= counter_in;
         out_pin_a_ff <= level_a_in;
         out_pin_b_ff <= level_b_in;
         out_ovf_ff   <= ovf_in;
         out_ma_ff    <= ma_in;
         out_mb_ff    <= mb_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_count_value   = out_count_ff;
   assign rsp_pin_a         = out_pin_a_ff;
   assign rsp_pin_b         = out_pin_b_ff;
   assign rsp_overflow_flag = out_ovf_ff;
   assign rsp_match_a_flag  = out_ma_ff;
   assign rsp_match_b_flag  = out_mb_ff;

endmodule

`default_nettype wire

FILE: src/timer8_pwm_compare.sv
// Path: an accepted item is registered in the input register, then in the result register,
//   and its result leaves from the result register.
// Throughput: one item per cycle while rsp_ready holds; the counter and pin state update
//   in the same cycle the item leaves the input register, so the next item sees it right away.
// Stall: rsp_ready low holds the result; an empty input register still takes one item.
// Reset (synchronous, active high): counter 0, counting up, both pins low, all config 0.
`default_nettype none

module timer8_pwm_compare (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration write channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tpc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [tpc_pkg::CsrDataWidth-1:0]    csr_data,
   // tick items in
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [tpc_pkg::PrescaleWidth-1:0]   req_prescale_count,
   // result items out
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [tpc_pkg::CountWidth-1:0]           rsp_count_value,
   output logic                                     rsp_pin_a,
   output logic                                     rsp_pin_b,
   output logic                                     rsp_overflow_flag,
   output logic                                     rsp_match_a_flag,
   output logic                                     rsp_match_b_flag
);
   import tpc_pkg::*;

   cfg_type cfg;

   // registers are always writable; write them only while no item is in flight
   assign csr_ready = 1'b1;

   tpc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // hold the tick in the input register, step the timer, and drop the item into
   // the result register
   tpc_core u_core (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_prescale_count (req_prescale_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_count_value    (rsp_count_value),
      .rsp_pin_a          (rsp_pin_a),
      .rsp_pin_b          (rsp_pin_b),
      .rsp_overflow_flag  (rsp_overflow_flag),
      .rsp_match_a_flag   (rsp_match_a_flag),
      .rsp_match_b_flag   (rsp_match_b_flag)
   );

endmodule

`default_nettype wire

FILE: tb/timer8_pwm_compare_tb.sv
`timescale 1ns / 1ps

module timer8_pwm_compare_tb;

   import tpc_pkg::*;

   // mode codes above fast PWM act as a plain up-counter; the top one stands for them all
   localparam logic [ModeWidth-1:0] ModeUpOnly = 3'd7;

   // clock select codes used by name below
   localparam logic [ClockSelWidth-1:0] ClkStop    = 3'd0;
   localparam logic [ClockSelWidth-1:0] ClkDiv1    = 3'd1;
   localparam logic [ClockSelWidth-1:0] ClkDiv8    = 3'd2;
   localparam logic [ClockSelWidth-1:0] ClkDiv1024 = 3'd7;

   localparam int unsigned RandomTicks  = 1050;
   localparam int unsigned IdlePercent  = 34;
   localparam int unsigned ReportLimit  = 10;
   localparam int unsigned DrainCycles  = 3;

   typedef struct packed {
      logic [CountWidth-1:0] count_value;
      logic                  pin_a;
      logic                  pin_b;
      logic                  overflow;
      logic                  match_a;
      logic                  match_b;
   } tick_result_type;

   typedef enum logic {RowWrite, RowTick} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [CsrIndexWidth-1:0] index;
      logic [CsrDataWidth-1:0]  data;
      logic [PrescaleWidth-1:0] prescale;
      logic                     typed;
      tick_result_type          want;
   } opening_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_data  = '0;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [PrescaleWidth-1:0] req_prescale_count = '0;

   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [CountWidth-1:0]    rsp_count_value;
   logic                     rsp_pin_a;
   logic                     rsp_pin_b;
   logic                     rsp_overflow_flag;
   logic                     rsp_match_a_flag;
   logic                     rsp_match_b_flag;

   timer8_pwm_compare dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_prescale_count (req_prescale_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_count_value    (rsp_count_value),
      .rsp_pin_a          (rsp_pin_a),
      .rsp_pin_b          (rsp_pin_b),
      .rsp_overflow_flag  (rsp_overflow_flag),
      .rsp_match_a_flag   (rsp_match_a_flag),
      .rsp_match_b_flag   (rsp_match_b_flag)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Timer mirror: registers and state as the block should hold them.
   cfg_type         timer_cfg = '0;
   logic [CountWidth-1:0] timer_count = CountBottom;
   logic            timer_counting_up = 1'b1;
   logic            level_a = 1'b0;
   logic            level_b = 1'b0;

   // Outputs owed by the block, oldest first.
   tick_result_type tick_outputs_due[$];
   opening_row_type opening_rows[$];

   // Hold both sides busy every cycle while set.
   logic            quiet = 1'b0;

   int unsigned     fail_count = 0;
   int unsigned     ticks_sent = 0;
   int unsigned     results_seen = 0;
   int unsigned     reg_writes = 0;
   int unsigned     phases_run = 0;
   int unsigned     seen_overflow = 0;
   int unsigned     seen_match_a = 0;
   int unsigned     seen_match_b = 0;
   int unsigned     seen_count_down = 0;

   tick_result_type got_result;
   tick_result_type want_result;

   // Low prescaler bits that must all be zero for a counting tick.
   function automatic logic [PrescaleWidth-1:0] prescale_mask(
      input logic [ClockSelWidth-1:0] sel
   );
      int shift;
      logic [PrescaleWidth-1:0] mask;
      case (sel)
         3'd2:    shift = 3;
         3'd3:    shift = 5;
         3'd4:    shift = 6;
         3'd5:    shift = 7;
         3'd6:    shift = 8;
         3'd7:    shift = 10;
         default: shift = 0;
      endcase
      mask = (10'd1 << shift) - 10'd1;
      return mask;
   endfunction

   // Pin level after a compare hit: action meaning depends on the waveform mode,
   // and phase-correct mode flips clear/set on the way down.
   function automatic logic pin_after_match(
      input logic [ModeWidth-1:0]   mode,
      input logic [ActionWidth-1:0] action,
      input logic                   level,
      input logic                   up
   );
      logic next;
      next = level;
      case (mode)
         ModeNormal, ModeCtc: begin
            if (action == ActToggle) next = !level;
            else if (action == ActClear) next = 1'b0;
            else if (action == ActSet) next = 1'b1;
         end
         ModePhasePwm: begin
            if (action == ActClear) next = !up;
            else if (action == ActSet) next = up;
         end
         ModeFastPwm: begin
            if (action == ActClear) next = 1'b0;
            else if (action == ActSet) next = 1'b1;
         end
         default: next = level;
      endcase
      return next;
   endfunction

   // Fast PWM drives the pin opposite to its compare action when the counter wraps.
   function automatic logic pin_after_wrap(
      input logic [ModeWidth-1:0]   mode,
      input logic [ActionWidth-1:0] action,
      input logic                   level
   );
      logic next;
      next = level;
      if (mode == ModeFastPwm) begin
         if (action == ActClear) next = 1'b1;
         else if (action == ActSet) next = 1'b0;
      end
      return next;
   endfunction

   // Advance the timer mirror by one CPU tick and return what the block should show.
   task automatic step_timer(input logic [PrescaleWidth-1:0] pre, output tick_result_type r);
      logic                  up;
      logic [CountWidth-1:0] top_a;
      logic [CountWidth-1:0] top_b;
      r = '0;
      if (timer_cfg.clock_select != ClkStop &&
          (pre & prescale_mask(timer_cfg.clock_select)) == '0) begin
         up = (timer_cfg.wave_mode == ModePhasePwm) ? timer_counting_up : 1'b1;
         if (!up) seen_count_down++;
         timer_count = up ? timer_count + 8'd1 : timer_count - 8'd1;
         if (timer_cfg.wave_mode == ModePhasePwm) r.overflow = (timer_count == CountBottom);
         else r.overflow = (timer_count == CountTop);
         if (timer_count == timer_cfg.compare_a) begin
            r.match_a = 1'b1;
            level_a = pin_after_match(timer_cfg.wave_mode, timer_cfg.out_action_a, level_a, up);
         end
         if (timer_count == timer_cfg.compare_b) begin
            r.match_b = 1'b1;
            level_b = pin_after_match(timer_cfg.wave_mode, timer_cfg.out_action_b, level_b, up);
         end
         if (timer_cfg.wave_mode == ModeNormal || timer_cfg.wave_mode == ModeCtc ||
             timer_cfg.wave_mode == ModeFastPwm) begin
            // CTC wraps at the compare values, the others at the full count;
            // the B check sees the counter after a possible A wrap
            top_a = (timer_cfg.wave_mode == ModeCtc) ? timer_cfg.compare_a : CountTop;
            top_b = (timer_cfg.wave_mode == ModeCtc) ? timer_cfg.compare_b : CountTop;
            if (timer_count == top_a) begin
               timer_count = CountBottom;
               level_a = pin_after_wrap(timer_cfg.wave_mode, timer_cfg.out_action_a, level_a);
            end
            if (timer_count == top_b) begin
               timer_count = CountBottom;
               level_b = pin_after_wrap(timer_cfg.wave_mode, timer_cfg.out_action_b, level_b);
            end
         end else if (timer_cfg.wave_mode == ModePhasePwm) begin
            // turn around at the full count, and again at bottom
            if (timer_counting_up && timer_count == CountTop) timer_counting_up = 1'b0;
            else if (!timer_counting_up && timer_count == CountBottom) timer_counting_up = 1'b1;
         end
      end
      r.count_value = timer_count;
      r.pin_a = level_a;
      r.pin_b = level_b;
   endtask

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= ReportLimit) $display("[%0t] %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want)
         note_failure($sformatf("result %0d: %s expected %0h, got %0h",
                                results_seen, name, want, got));
   endtask

   // Drop valid, then wait until every owed result is back and the pipe is empty.
   task automatic wait_drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (tick_outputs_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Write one register; valid stays up so back-to-back writes need no second assignment.
   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         RegWaveMode: timer_cfg.wave_mode    = value[ModeWidth-1:0];
         RegClockSel: timer_cfg.clock_select = value[ClockSelWidth-1:0];
         RegCompareA: timer_cfg.compare_a    = value;
         RegCompareB: timer_cfg.compare_b    = value;
         RegActionA:  timer_cfg.out_action_a = value[ActionWidth-1:0];
         RegActionB:  timer_cfg.out_action_b = value[ActionWidth-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   // Offer one tick item; log what it owes at the edge it is taken.
   task automatic send_tick(input logic [PrescaleWidth-1:0] pre, input logic typed,
                            input tick_result_type want);
      tick_result_type predicted;
      if (csr_valid) csr_valid <= 1'b0;
      while (!quiet && $urandom_range(99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_prescale_count <= pre;
      do @(posedge clock); while (!req_ready);
      step_timer(pre, predicted);
      tick_outputs_due.push_back(typed ? want : predicted);
      ticks_sent++;
   endtask

   task automatic add_write(input logic [CsrIndexWidth-1:0] idx, input logic [7:0] value);
      opening_row_type row;
      row = '0;
      row.kind = RowWrite;
      row.index = idx;
      row.data = value;
      opening_rows.push_back(row);
   endtask

   task automatic add_tick(input logic [PrescaleWidth-1:0] pre, input logic typed,
                           input tick_result_type want);
      opening_row_type row;
      row = '0;
      row.kind = RowTick;
      row.prescale = pre;
      row.typed = typed;
      row.want = want;
      opening_rows.push_back(row);
   endtask

   // Randomize the receiver side; quiet stretches keep it always ready.
   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= IdlePercent);
   end

   // Check every result taken against the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_result = {rsp_count_value, rsp_pin_a, rsp_pin_b, rsp_overflow_flag,
                       rsp_match_a_flag, rsp_match_b_flag};
         if (tick_outputs_due.size() == 0) begin
            note_failure($sformatf("result with nothing owed: %0h", got_result));
         end else begin
            want_result = tick_outputs_due.pop_front();
            check_field("count_value", want_result.count_value, got_result.count_value);
            check_field("pin_a", want_result.pin_a, got_result.pin_a);
            check_field("pin_b", want_result.pin_b, got_result.pin_b);
            check_field("overflow_flag", want_result.overflow, got_result.overflow);
            check_field("match_a_flag", want_result.match_a, got_result.match_a);
            check_field("match_b_flag", want_result.match_b, got_result.match_b);
            if (want_result.overflow) seen_overflow++;
            if (want_result.match_a) seen_match_a++;
            if (want_result.match_b) seen_match_b++;
         end
         results_seen++;
      end
   end

   initial begin
      // Generous bound on the length of a correct run.
      #2_000_000;
      $display("timed out with %0d results still owed", tick_outputs_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      logic [PrescaleWidth-1:0] pre;
      logic [PrescaleWidth-1:0] pre_run;
      logic [ModeWidth-1:0]     mode;
      logic [ClockSelWidth-1:0] sel;
      logic [7:0]               cmp_a;
      logic [7:0]               cmp_b;
      int unsigned              phase_len;
      int unsigned              random_ticks;
      int unsigned              roll;
      logic                     last_was_tick;
      opening_row_type          row;

      // Directed opening. Stopped timer after reset, both prescaler extremes.
      add_tick(10'h000, 1'b1, {8'd0, 5'b00000});
      add_tick(10'h3FF, 1'b1, {8'd0, 5'b00000});
      // Divide by one, toggle A on a hit at 1: first tick lands on it.
      add_write(RegClockSel, 8'(ClkDiv1));
      add_write(RegCompareA, 8'd1);
      add_write(RegActionA, 8'(ActToggle));
      add_tick(10'h155, 1'b1, {8'd1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0});
      // Divide by eight: a prescaler value off the boundary holds everything.
      add_write(RegClockSel, 8'(ClkDiv8));
      add_tick(10'h007, 1'b1, {8'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0});
      add_tick(10'h008, 1'b0, '0);
      // CTC with B as the lower top, set B on its hit, slowest divisor.
      add_write(RegWaveMode, 8'(ModeCtc));
      add_write(RegCompareA, 8'd4);
      add_write(RegCompareB, 8'd3);
      add_write(RegActionB, 8'(ActSet));
      add_write(RegClockSel, 8'(ClkDiv1024));
      add_tick(10'h000, 1'b0, '0);
      add_tick(10'h3FF, 1'b0, '0);
      add_tick(10'h000, 1'b0, '0);
      // Phase-correct: clear on A, set on B, counting every tick.
      add_write(RegWaveMode, 8'(ModePhasePwm));
      add_write(RegClockSel, 8'(ClkDiv1));
      add_write(RegCompareA, 8'd2);
      add_write(RegActionA, 8'(ActClear));
      add_write(RegCompareB, 8'd1);
      add_write(RegActionB, 8'(ActSet));
      add_tick(10'h2AA, 1'b0, '0);
      add_tick(10'h155, 1'b0, '0);
      add_tick(10'h3FF, 1'b0, '0);
      // Fast PWM with compare extremes.
      add_write(RegWaveMode, 8'(ModeFastPwm));
      add_write(RegCompareA, 8'hFF);
      add_write(RegActionA, 8'(ActSet));
      add_write(RegCompareB, 8'h00);
      add_write(RegActionB, 8'(ActClear));
      add_tick(10'h100, 1'b0, '0);
      add_tick(10'h200, 1'b0, '0);
      // Upper mode codes: flags only, pins untouched.
      add_write(RegWaveMode, 8'(ModeUpOnly));
      add_tick(10'h001, 1'b0, '0);
      add_tick(10'h3FE, 1'b0, '0);
      // Toggle with no action on A, then stop the clock.
      add_write(RegActionA, 8'(ActNone));
      add_write(RegActionB, 8'(ActToggle));
      add_write(RegClockSel, 8'(ClkStop));
      add_tick(10'h000, 1'b0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      last_was_tick = 1'b0;
      foreach (opening_rows[i]) begin
         row = opening_rows[i];
         if (row.kind == RowWrite) begin
            if (last_was_tick) wait_drain();
            write_reg(row.index, row.data);
            last_was_tick = 1'b0;
         end else begin
            send_tick(row.prescale, row.typed, row.want);
            last_was_tick = 1'b1;
         end
      end

      // Random phases: a fresh register set, then a run of ticks. The first two
      // phases are long enough to sweep the full count in phase-correct and normal.
      pre_run = '0;
      random_ticks = 0;
      while (random_ticks < RandomTicks) begin
         wait_drain();
         if (phases_run == 0) begin
            mode = ModePhasePwm;
            sel = ClkDiv1;
            phase_len = 560;
         end else if (phases_run == 1) begin
            mode = ModeNormal;
            sel = ClkDiv1;
            phase_len = 270;
         end else begin
            mode = ($urandom_range(9) < 8) ? 3'($urandom_range(ModeFastPwm))
                                           : 3'($urandom_range(ModeUpOnly, ModeFastPwm + 1));
            roll = $urandom_range(99);
            if (roll < 5) sel = ClkStop;
            else if (roll < 55) sel = ClkDiv1;
            else sel = 3'($urandom_range(ClkDiv1024, ClkDiv8));
            phase_len = $urandom_range(120, 20);
         end
         roll = $urandom_range(9);
         cmp_a = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hFF : 8'($urandom_range(255));
         roll = $urandom_range(9);
         cmp_b = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hFF : 8'($urandom_range(255));
         write_reg(RegWaveMode, 8'(mode));
         write_reg(RegClockSel, 8'(sel));
         write_reg(RegCompareA, cmp_a);
         write_reg(RegCompareB, cmp_b);
         write_reg(RegActionA, 8'($urandom_range(ActSet)));
         write_reg(RegActionB, 8'($urandom_range(ActSet)));
         quiet <= (phases_run == 2);
         for (int unsigned n = 0; n < phase_len; n++) begin
            // hold off once mid-phase until everything owed has come back
            if (phases_run == 3 && n == phase_len / 2) wait_drain();
            roll = $urandom_range(99);
            if (roll < 50) begin
               pre_run = pre_run + 10'd1;
               pre = pre_run;
            end else if (roll < 80) begin
               pre = 10'($urandom_range(1023)) & ~prescale_mask(timer_cfg.clock_select);
            end else begin
               pre = 10'($urandom_range(1023));
            end
            send_tick(pre, 1'b0, '0);
            random_ticks++;
         end
         phases_run++;
      end

      wait_drain();
      quiet <= 1'b0;
      repeat (10) @(posedge clock);

      $display("ran %0d ticks over %0d random register sets with %0d writes, %0d results",
               ticks_sent, phases_run, reg_writes, results_seen);
      $display("overflows %0d, A hits %0d, B hits %0d, down-count ticks %0d",
               seen_overflow, seen_match_a, seen_match_b, seen_count_down);
      if (fail_count == 0 && tick_outputs_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d failures", fail_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
